// ===== sv/erl_pkg.sv =====
// Shared types and constants for the executable range table.
// No dependencies; imported by erl_mod, erl_front, erl_back, the top level and the testbench.
package erl_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int DW              = 64;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_LOAD     = 2'd1,
        CMD_FIND_VA  = 2'd2,
        CMD_FIND_OFF = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // One classified word as it waits between front and back.
    typedef struct packed {
        cmd_t            cmd;
        logic            hdr_ok;
        logic            query_bad;
        logic [DW-1:0]   vaddr;
        logic [DW-1:0]   vend;
        logic [DW-1:0]   foff;
        logic [DW-1:0]   align;
        logic [DW-1:0]   q1;
        logic [DW-1:0]   q2;
        logic [DW-1:0]   qend;
    } job_t;

endpackage

// ===== sv/erl_if.sv =====
// Handshake channels of the executable range table.
// Plain widths; used by erl_front, erl_back and the top level.
interface erl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] seg_type;
    logic [31:0] seg_flags;
    logic [63:0] seg_vaddr;
    logic [63:0] seg_memsz;
    logic [63:0] seg_file_offset;
    logic [63:0] seg_align;
    logic [63:0] query_first;
    logic [63:0] query_second;

    modport source (output valid, cmd, seg_type, seg_flags, seg_vaddr, seg_memsz,
                    seg_file_offset, seg_align, query_first, query_second,
                    input ready);
    modport sink (input valid, cmd, seg_type, seg_flags, seg_vaddr, seg_memsz,
                  seg_file_offset, seg_align, query_first, query_second,
                  output ready);
endinterface

interface erl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        found;
    logic [63:0] mapped_addr;
    logic [4:0]  entry_count;
    logic [63:0] first_start;

    modport source (output valid, status, found, mapped_addr, entry_count, first_start,
                    input ready);
    modport sink (input valid, status, found, mapped_addr, entry_count, first_start,
                  output ready);
endinterface

// ===== sv/erl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module erl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/erl_mod.sv =====
// Bit-serial 64-bit remainder unit: one restoring step per cycle.
// Depends on erl_pkg. A divisor of zero yields a zero remainder.
module erl_mod import erl_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] value,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(DW);

    logic [DW-1:0] r_reg, v_reg, a_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   sh;
    logic [DW:0]   diff;

    assign sh   = {r_reg, v_reg[DW-1]};
    assign diff = sh - {1'b0, a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            v_reg <= value;
            a_reg <= divisor;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[DW-2:0], 1'b0};
            r_reg <= diff[DW] ? sh[DW-1:0] : diff[DW-1:0];
        end
    end

    assign done = done_reg;
    // a zero divisor leaves the value unaligned, so report no remainder
    assign rem  = (a_reg == '0) ? '0 : r_reg;

endmodule

// ===== sv/erl_front.sv =====
// Front end: accepts request words, classifies them and queues them two deep.
// Depends on erl_pkg and erl_req_if.
module erl_front import erl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    erl_req_if.sink   req,
    output job_t      head,
    output logic      head_valid,
    input  logic      pop
);

    job_t        q_mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    job_t        job_in;
    logic        push;
    logic [DW:0] qsum;

    assign qsum = {1'b0, req.query_first} + {1'b0, req.query_second};

    always_comb
    begin
        job_in.cmd    = cmd_t'(req.cmd);
        job_in.hdr_ok = (req.seg_type == 32'd1) && req.seg_flags[0] && (req.seg_memsz != '0);
        job_in.vaddr  = req.seg_vaddr;
        job_in.vend   = req.seg_vaddr + req.seg_memsz;
        job_in.foff   = req.seg_file_offset;
        job_in.align  = req.seg_align;
        job_in.q1     = req.query_first;
        job_in.q2     = req.query_second;
        job_in.qend   = qsum[DW-1:0];
        if (req.cmd == CMD_FIND_VA)
        begin
            job_in.query_bad = req.query_second <= req.query_first;
        end
        else
        begin
            job_in.query_bad = (req.query_second == '0) || qsum[DW];
        end
    end

    assign req.ready  = cnt_reg != 2'd2;
    assign push       = req.valid && req.ready;
    assign head_valid = cnt_reg != 2'd0;
    assign head       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// ===== sv/erl_back.sv =====
// Back end: executes queued words against the range table, drives the response.
// Depends on erl_pkg, erl_rsp_if, erl_ram and erl_mod.
module erl_back import erl_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  logic      head_valid,
    output logic      pop,
    erl_rsp_if.source rsp
);

    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_LOAD, S_RD, S_CMP, S_CMP2, S_OUT
    } state_t;

    state_t          st_reg;
    job_t            job_reg;
    logic [CNTW-1:0] count_reg, idx_reg;
    logic [DW-1:0]   first_reg, s_reg, e_reg, o_reg, len_reg;
    logic [1:0]      status_reg;
    logic            found_reg;
    logic [DW-1:0]   addr_reg;
    logic            ov_reg;
    logic [1:0]      o_status_reg;
    logic            o_found_reg;
    logic [DW-1:0]   o_addr_reg, o_first_reg;
    logic [4:0]      o_count_reg;

    logic                mod_start, mod_done, d1, d2;
    logic [DW-1:0]       r0, r1, r2;
    logic                we;
    logic [3*DW-1:0]     rdata;
    logic [DW-1:0]       ds, de, dof;
    logic [DW:0]         rend;
    logic [CNTW-1:0]     idx_inc;

    assign mod_start = (st_reg == S_IDLE) && head_valid && (head.cmd == CMD_LOAD) && head.hdr_ok;
    assign pop       = (st_reg == S_IDLE) && head_valid;

    erl_mod u_mod_s (.clk, .rst_n, .start(mod_start), .value(head.vaddr),
                     .divisor(head.align), .done(mod_done), .rem(r0));
    erl_mod u_mod_e (.clk, .rst_n, .start(mod_start), .value(head.vend),
                     .divisor(head.align), .done(d1), .rem(r1));
    erl_mod u_mod_o (.clk, .rst_n, .start(mod_start), .value(head.foff),
                     .divisor(head.align), .done(d2), .rem(r2));

    assign we = (st_reg == S_LOAD) && (e_reg > s_reg) && (count_reg < CNTW'(MAX_ENTRIES));

    erl_ram #(.WIDTH(3*DW), .DEPTH(MAX_ENTRIES), .AW(IW)) u_tab (
        .clk,
        .we,
        .waddr (count_reg[IW-1:0]),
        .wdata ({s_reg, e_reg, o_reg}),
        .raddr (idx_reg[IW-1:0]),
        .rdata
    );

    assign {ds, de, dof} = rdata;
    assign rend    = {1'b0, dof} + {1'b0, len_reg};
    assign idx_inc = idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            // S_OUT reloads the output word itself when the old one leaves
            if (ov_reg && rsp.ready && (st_reg != S_OUT))
            begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        job_reg    <= head;
                        found_reg  <= 1'b0;
                        addr_reg   <= '0;
                        idx_reg    <= '0;
                        case (head.cmd)
                            CMD_CLEAR:
                            begin
                                status_reg <= ST_DONE;
                                count_reg  <= '0;
                                st_reg     <= S_OUT;
                            end
                            CMD_LOAD:
                            begin
                                if (head.hdr_ok)
                                begin
                                    status_reg <= ST_DONE;
                                    st_reg     <= S_MOD;
                                end
                                else
                                begin
                                    status_reg <= ST_SKIP;
                                    st_reg     <= S_OUT;
                                end
                            end
                            default:
                            begin
                                if (head.query_bad)
                                begin
                                    status_reg <= ST_SKIP;
                                    st_reg     <= S_OUT;
                                end
                                else if (count_reg == '0)
                                begin
                                    status_reg <= ST_DONE;
                                    st_reg     <= S_OUT;
                                end
                                else
                                begin
                                    status_reg <= ST_DONE;
                                    st_reg     <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_MOD:
                begin
                    if (mod_done && d1 && d2)
                    begin
                        s_reg  <= job_reg.vaddr - r0;
                        e_reg  <= (r1 == '0) ? job_reg.vend : job_reg.vend + (job_reg.align - r1);
                        o_reg  <= job_reg.foff - r2;
                        st_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (e_reg <= s_reg)
                    begin
                        status_reg <= ST_SKIP;
                    end
                    else if (count_reg >= CNTW'(MAX_ENTRIES))
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (count_reg == '0)
                        begin
                            first_reg <= s_reg;
                        end
                    end
                    st_reg <= S_OUT;
                end
                S_RD:
                begin
                    st_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (job_reg.cmd == CMD_FIND_VA)
                    begin
                        if (job_reg.q1 >= ds && job_reg.q2 <= de)
                        begin
                            found_reg <= 1'b1;
                            addr_reg  <= job_reg.q1;
                            st_reg    <= S_OUT;
                        end
                        else
                        begin
                            idx_reg <= idx_inc;
                            st_reg  <= (idx_inc == count_reg) ? S_OUT : S_RD;
                        end
                    end
                    else if (de <= ds)
                    begin
                        idx_reg <= idx_inc;
                        st_reg  <= (idx_inc == count_reg) ? S_OUT : S_RD;
                    end
                    else
                    begin
                        len_reg <= de - ds;
                        st_reg  <= S_CMP2;
                    end
                end
                S_CMP2:
                begin
                    // skip entries whose offset range wraps past the top
                    if (!rend[DW] && job_reg.q1 >= dof && job_reg.qend <= rend[DW-1:0])
                    begin
                        found_reg <= 1'b1;
                        addr_reg  <= ds + (job_reg.q1 - dof);
                        st_reg    <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                        st_reg  <= (idx_inc == count_reg) ? S_OUT : S_RD;
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || rsp.ready)
                    begin
                        ov_reg       <= 1'b1;
                        o_status_reg <= status_reg;
                        o_found_reg  <= found_reg;
                        o_addr_reg   <= addr_reg;
                        o_count_reg  <= 5'(count_reg);
                        o_first_reg  <= (count_reg == '0) ? '0 : first_reg;
                        st_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = ov_reg;
    assign rsp.status      = o_status_reg;
    assign rsp.found       = o_found_reg;
    assign rsp.mapped_addr = o_addr_reg;
    assign rsp.entry_count = o_count_reg;
    assign rsp.first_start = o_first_reg;

endmodule

// ===== sv/exec_range_table_lookup.sv =====
// Top level of the executable range table: front end, word queue, back end.
// Depends on erl_pkg, erl_if, erl_front and erl_back.
//
// Keeps up to MAX_ENTRIES executable ranges built from program headers and
// answers one response word per request word. A load runs three 64-bit
// remainder units side by side, one bit per cycle, for the start, end and
// file-offset alignment. A lookup scans the table entry by entry through
// its single read port. A two-word queue lets new requests be taken while
// the back end works or its response waits.
module exec_range_table_lookup import erl_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    erl_req_if.sink   req,
    erl_rsp_if.source rsp
);

    job_t head;
    logic head_valid;
    logic pop;

    erl_front u_front (
        .clk,
        .rst_n,
        .req,
        .head,
        .head_valid,
        .pop
    );

    erl_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk,
        .rst_n,
        .head,
        .head_valid,
        .pop,
        .rsp
    );

endmodule

// ===== sim/tb_exec_range_table_lookup.sv =====
// Testbench for exec_range_table_lookup: directed and random clear, load and lookup words,
// checked against a cycle-free table predictor held in a small scoreboard class.
// Depends on erl_pkg, erl_if and the exec_range_table_lookup RTL.
`timescale 1ns / 1ps

module tb_exec_range_table_lookup;
    import erl_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] seg_type;
        logic [31:0] seg_flags;
        logic [63:0] seg_vaddr;
        logic [63:0] seg_memsz;
        logic [63:0] seg_file_offset;
        logic [63:0] seg_align;
        logic [63:0] query_first;
        logic [63:0] query_second;
    } req_word_t;

    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic [63:0] mapped_addr;
        logic [4:0]  entry_count;
        logic [63:0] first_start;
    } rsp_word_t;

    class range_table_scoreboard;
        logic [63:0] starts [TABLE_DEPTH];
        logic [63:0] ends [TABLE_DEPTH];
        logic [63:0] offsets [TABLE_DEPTH];
        int          count;
        rsp_word_t   pending_rsp [$];
        int          errors;
        int          loads_taken;
        int          loads_full;
        int          va_hits;
        int          off_hits;

        function logic [63:0] floor_to_align(logic [63:0] v, logic [63:0] a);
            if (a == 0)
                return v;
            return v - (v % a);
        endfunction

        function logic [63:0] ceil_to_align(logic [63:0] v, logic [63:0] a);
            logic [63:0] r;
            if (a == 0)
                return v;
            r = v % a;
            if (r == 0)
                return v;
            return v + (a - r);
        endfunction

        function void note(req_word_t w);
            rsp_word_t   r;
            logic [63:0] s, e, qend, len;
            int          n;
            r = '{ST_DONE, 1'b0, 64'd0, 5'd0, 64'd0};
            n = count;
            case (w.cmd)
                CMD_CLEAR: count = 0;
                CMD_LOAD:
                begin
                    if (w.seg_type != 32'd1 || !w.seg_flags[0] || w.seg_memsz == 0)
                        r.status = ST_SKIP;
                    else
                    begin
                        s = floor_to_align(w.seg_vaddr, w.seg_align);
                        e = ceil_to_align(w.seg_vaddr + w.seg_memsz, w.seg_align);
                        if (e <= s)
                            r.status = ST_SKIP;
                        else if (n >= TABLE_DEPTH)
                        begin
                            r.status = ST_FULL;
                            loads_full++;
                        end
                        else
                        begin
                            starts[n] = s;
                            ends[n] = e;
                            offsets[n] = floor_to_align(w.seg_file_offset, w.seg_align);
                            count = n + 1;
                            loads_taken++;
                        end
                    end
                end
                CMD_FIND_VA:
                begin
                    if (w.query_second <= w.query_first)
                        r.status = ST_SKIP;
                    else
                        for (int i = 0; i < n && !r.found; i++)
                            if (w.query_first >= starts[i] && w.query_second <= ends[i])
                            begin
                                r.found = 1'b1;
                                r.mapped_addr = w.query_first;
                                va_hits++;
                            end
                end
                default:
                begin
                    if (w.query_second == 0 || w.query_first > ALL_ONES - w.query_second)
                        r.status = ST_SKIP;
                    else
                    begin
                        qend = w.query_first + w.query_second;
                        for (int i = 0; i < n && !r.found; i++)
                        begin
                            if (ends[i] <= starts[i])
                                continue;
                            len = ends[i] - starts[i];
                            if (offsets[i] > ALL_ONES - len)
                                continue;
                            if (w.query_first >= offsets[i] && qend <= offsets[i] + len)
                            begin
                                r.found = 1'b1;
                                r.mapped_addr = starts[i] + (w.query_first - offsets[i]);
                                off_hits++;
                            end
                        end
                    end
                end
            endcase
            r.entry_count = count[4:0];
            r.first_start = (count == 0) ? 64'd0 : starts[0];
            pending_rsp.push_back(r);
        endfunction

        function void check(rsp_word_t a);
            rsp_word_t x;
            if (pending_rsp.size() == 0)
            begin
                $error("response word with nothing outstanding");
                errors++;
                return;
            end
            x = pending_rsp.pop_front();
            if (a.status !== x.status)
            begin
                $error("status expected %0d got %0d", x.status, a.status);
                errors++;
            end
            if (a.found !== x.found)
            begin
                $error("found expected %0d got %0d", x.found, a.found);
                errors++;
            end
            if (a.mapped_addr !== x.mapped_addr)
            begin
                $error("mapped_addr expected %h got %h", x.mapped_addr, a.mapped_addr);
                errors++;
            end
            if (a.entry_count !== x.entry_count)
            begin
                $error("entry_count expected %0d got %0d", x.entry_count, a.entry_count);
                errors++;
            end
            if (a.first_start !== x.first_start)
            begin
                $error("first_start expected %h got %h", x.first_start, a.first_start);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    erl_req_if req_ch ();
    erl_rsp_if rsp_ch ();

    exec_range_table_lookup DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    range_table_scoreboard table_sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_go;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("exec_range_table_lookup verification failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly powers of two, with some zero, odd and full-width alignments.
    function automatic logic [63:0] rand_align();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 64'd0;
        if (pick < 75)
            return 64'd1 << $urandom_range(16);
        if (pick < 90)
            return 64'($urandom_range(1000, 1));
        return rand64();
    endfunction

    function automatic req_word_t blank_word(cmd_t c);
        req_word_t w;
        w = '{c, 32'd0, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
        return w;
    endfunction

    function automatic req_word_t load_word(logic [31:0] t, logic [31:0] f, logic [63:0] va,
                                            logic [63:0] sz, logic [63:0] fo, logic [63:0] al);
        req_word_t w;
        w = blank_word(CMD_LOAD);
        w.seg_type = t;
        w.seg_flags = f;
        w.seg_vaddr = va;
        w.seg_memsz = sz;
        w.seg_file_offset = fo;
        w.seg_align = al;
        return w;
    endfunction

    function automatic req_word_t query_word(cmd_t c, logic [63:0] q1, logic [63:0] q2);
        req_word_t w;
        w = blank_word(c);
        w.query_first = q1;
        w.query_second = q2;
        return w;
    endfunction

    task automatic send(req_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.cmd <= w.cmd;
        req_ch.seg_type <= w.seg_type;
        req_ch.seg_flags <= w.seg_flags;
        req_ch.seg_vaddr <= w.seg_vaddr;
        req_ch.seg_memsz <= w.seg_memsz;
        req_ch.seg_file_offset <= w.seg_file_offset;
        req_ch.seg_align <= w.seg_align;
        req_ch.query_first <= w.query_first;
        req_ch.query_second <= w.query_second;
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        table_sb.note(w);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (table_sb.pending_rsp.size() != 0)
            @(posedge clk);
        // then let both channels sit idle before going on
        repeat (100) @(posedge clk);
    endtask

    task automatic send_random();
        req_word_t   w;
        int          pick, i;
        logic [63:0] base, q1, span;
        pick = $urandom_range(99);
        if (pick < 4)
            w = blank_word(CMD_CLEAR);
        else if (pick < 40)
        begin
            if ($urandom_range(99) < 80)
            begin
                base = ($urandom_range(9) == 0) ? rand64() : 64'($urandom) << 8;
                span = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(65536, 1));
                w = load_word(32'd1, $urandom | 32'd1, base, span,
                              ($urandom_range(4) == 0) ? rand64() : 64'($urandom),
                              rand_align());
            end
            else
                w = load_word(($urandom_range(1)) ? 32'd1 : $urandom, $urandom, rand64(),
                              ($urandom_range(3) == 0) ? 64'd0 : rand64(), rand64(),
                              rand_align());
        end
        else
        begin
            w = blank_word(($urandom_range(1)) ? CMD_FIND_VA : CMD_FIND_OFF);
            if (table_sb.count > 0 && $urandom_range(99) < 75)
            begin
                i = $urandom_range(table_sb.count - 1);
                if (w.cmd == CMD_FIND_VA)
                begin
                    span = table_sb.ends[i] - table_sb.starts[i];
                    q1 = table_sb.starts[i] + (rand64() % span);
                    w.query_first = q1;
                    w.query_second = q1 + 1 + (rand64() % (table_sb.ends[i] - q1));
                end
                else
                begin
                    span = table_sb.ends[i] - table_sb.starts[i];
                    q1 = rand64() % span;
                    w.query_first = table_sb.offsets[i] + q1;
                    w.query_second = 1 + (rand64() % (span - q1));
                end
                // nudge some past the edge of the range
                if ($urandom_range(9) == 0)
                    w.query_second = w.query_second + 64'($urandom_range(3));
            end
            else
            begin
                w.query_first = rand64();
                w.query_second = ($urandom_range(9) == 0) ? 64'd0 : rand64();
            end
        end
        send(w);
    endtask

    // Response side: check every accepted word, stall at random or on request.
    initial
    begin
        int        hold_left;
        rsp_word_t got;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.found = rsp_ch.found;
                got.mapped_addr = rsp_ch.mapped_addr;
                got.entry_count = rsp_ch.entry_count;
                got.first_start = rsp_ch.first_start;
                table_sb.check(got);
            end
            if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        table_sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd <= CMD_CLEAR;
        req_ch.seg_type <= '0;
        req_ch.seg_flags <= '0;
        req_ch.seg_vaddr <= '0;
        req_ch.seg_memsz <= '0;
        req_ch.seg_file_offset <= '0;
        req_ch.seg_align <= '0;
        req_ch.query_first <= '0;
        req_ch.query_second <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, rejected headers, alignment corners, lookups, a full table and a clear
        send(query_word(CMD_FIND_VA, 64'h1000, 64'h1001));
        send(load_word(32'd0, 32'd1, 64'h1000, 64'h100, 64'h0, 64'h0));
        send(load_word(32'd1, 32'd6, 64'h1000, 64'h100, 64'h0, 64'h0));
        send(load_word(32'd1, 32'd1, 64'h1000, 64'h0, 64'h0, 64'h0));
        send(load_word(32'd1, 32'd1, ALL_ONES - 64'hF, 64'h20, 64'h0, 64'h0));
        send(load_word(32'd1, 32'd1, ALL_ONES - 64'hFF, 64'h10, 64'h0, 64'h1000));
        send(load_word(32'd1, ALL_ONES[31:0], 64'h1234, 64'h100, 64'h567, 64'h1000));
        send(load_word(32'd1, 32'd1, 64'h20001, 64'h10, 64'h7, 64'd3));
        send(load_word(32'd1, 32'd1, 64'h1000, 64'h100, ALL_ONES - 64'hF, 64'h0));
        send(load_word(32'd1, 32'd1, 64'h5, 64'h10, 64'h9, ALL_ONES));
        send(query_word(CMD_FIND_VA, 64'h1100, 64'h1100));
        send(query_word(CMD_FIND_VA, 64'h1010, 64'h1080));
        send(query_word(CMD_FIND_VA, 64'h90000, 64'h90010));
        send(query_word(CMD_FIND_OFF, 64'h10, 64'h0));
        send(query_word(CMD_FIND_OFF, ALL_ONES, 64'h2));
        send(query_word(CMD_FIND_OFF, 64'h10, 64'h20));
        send(query_word(CMD_FIND_OFF, ALL_ONES - 64'hF, 64'h1));
        send(query_word(CMD_FIND_OFF, 64'h5000, 64'h1));
        for (int i = 0; i < 13; i++)
            send(load_word(32'd1, 32'd1, 64'h100000 * (i + 1), 64'h800, 64'h4000 * i, 64'h0));
        send(load_word(32'd1, 32'd1, 64'h9000000, 64'h10, 64'h0, 64'h0));
        send(blank_word(CMD_CLEAR));
        drain();

        // random: three idling mixes, with one long response hold and a full drain
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 63 : 0;
            recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 14 : 0;
            for (int k = 0; k < 500; k++)
            begin
                if (phase == 0 && k == 200)
                    hold_go = 1'b1;
                if (phase == 2 && k == 250)
                    drain();
                send_random();
            end
        end
        drain();

        $display("covered %0d loads stored, %0d dropped on full table",
                 table_sb.loads_taken, table_sb.loads_full);
        $display("lookups hit %0d by address and %0d by offset",
                 table_sb.va_hits, table_sb.off_hits);
        if (table_sb.errors == 0)
            $display("exec_range_table_lookup verification clean");
        else
            $display("exec_range_table_lookup verification failed");
        $finish;
    end

endmodule
